@@ rtl/pba_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_pkg: shared definitions for the port bitmap allocator
// Sizes of the bitmap, field widths, reset values of the registers,
// request and status codes, and the structs passed to and from the word scanner.
// ---------------------------------------------------------------------------
package pba_pkg;

    // Field widths
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 2;

    // Bitmap geometry (WORD_BITS is taken as a power of two)
    localparam int WORD_COUNT   = 2048;
    localparam int WORD_BITS    = 32;
    localparam int ADDR_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int BIT_CAPACITY = WORD_COUNT * WORD_BITS;
    localparam int CAP_W        = $clog2(BIT_CAPACITY + 1);
    // Width that holds any number, the capacity and an exclusive bound
    localparam int NUM_W        = (CAP_W > PORT_W + 1) ? CAP_W : PORT_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [PORT_W-1:0] RANGE_LO_RESET = PORT_W'(12000);
    localparam logic [PORT_W-1:0] RANGE_HI_RESET = PORT_W'(56000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI = CFG_IDX_W'(1);

    // Request codes
    localparam logic REQ_RESERVE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_NOT_RESERVED = 2'd2
    } t_status;

    // Window of one word that the scanner may hand out
    typedef struct packed {
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W-1:0] hi_bit;
        logic             use_lo;
        logic             use_hi;
    } t_scan_ctl;

    typedef struct packed {
        logic                 found;
        logic [BIT_W-1:0]     idx;
        logic [WORD_BITS-1:0] set_word;
    } t_scan_res;

endpackage

@@ rtl/pba_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_if: handshake channels of the port bitmap allocator
// Request, response and configuration write channels, each with valid,
// ready and its payload.
// ---------------------------------------------------------------------------
interface pba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [pba_pkg::PORT_W-1:0] port;

    modport source (output valid, output req_type, output port, input ready);
    modport sink   (input valid, input req_type, input port, output ready);
endinterface

interface pba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pba_pkg::PORT_W-1:0]   granted_port;
    logic [pba_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_port, output status, input ready);
    modport sink   (input valid, input granted_port, input status, output ready);
endinterface

interface pba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pba_pkg::CFG_IDX_W-1:0]  index;
    logic [pba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pba_bitmap_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_bitmap_ram: single write, single read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pba_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pba_word_scan.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pba_word_scan: lowest free bit finder for one bitmap word
// Masks the word to the allowed window, finds the lowest clear bit in it
// and returns the word with that bit set.
// ---------------------------------------------------------------------------
module pba_word_scan (
    input  logic [pba_pkg::WORD_BITS-1:0] i_word,
    input  pba_pkg::t_scan_ctl            i_ctl,
    output pba_pkg::t_scan_res            o_res
);
    import pba_pkg::*;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    logic [WORD_BITS-1:0] w_lo_mask;
    logic [WORD_BITS-1:0] w_hi_mask;
    logic [WORD_BITS-1:0] w_free;
    logic [BIT_W-1:0]     w_hi_shift;

    // Build the window mask
    assign w_hi_shift = BIT_W'(WORD_BITS - 1) - i_ctl.hi_bit;
    assign w_lo_mask  = i_ctl.use_lo ? (ALL_ONES << i_ctl.lo_bit) : ALL_ONES;
    assign w_hi_mask  = i_ctl.use_hi ? (ALL_ONES >> w_hi_shift) : ALL_ONES;
    assign w_free     = ~i_word & w_lo_mask & w_hi_mask;

    // Priority-encode the lowest free bit
    always_comb begin
        o_res.found = |w_free;
        o_res.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                o_res.idx = BIT_W'(i);
            end
        end
        o_res.set_word = i_word | (WORD_BITS'(1) << o_res.idx);
    end

endmodule

@@ rtl/port_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// port_bitmap_allocator: bitmap allocator for 16-bit numbers
// Reserves the lowest free number in the configured window [low, high) or
// releases a given number, one request at a time, with a bitmap held in
// block memory.
// ---------------------------------------------------------------------------
// After reset the bitmap is swept to zero, one word a cycle; the request
// channel is not ready during that pass, while configuration writes are
// taken throughout. A reserve examines the bitmap words in range in turn,
// each with a memory read and then the masked scan of that word, and then
// hands the result over. A release reads the word, tests and clears the
// bit, and hands the result over. The response sits in an output
// register, so the next request is accepted while a result waits to be taken.
// ---------------------------------------------------------------------------
module port_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pba_cfg_if.sink     i_cfg,
    pba_req_if.sink     i_req,
    pba_rsp_if.source   o_rsp
);
    import pba_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_SCAN_RD = 8'b0000_0100,
        S_SCAN_EV = 8'b0000_1000,
        S_REL_RD  = 8'b0001_0000,
        S_REL_EV  = 8'b0010_0000,
        S_DONE    = 8'b0100_0000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);
    localparam logic [NUM_W-1:0]  CAP_NUM   = NUM_W'(BIT_CAPACITY);

    t_state              r_state, n_state;
    logic [PORT_W-1:0]   r_low, r_high;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_word, n_word;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [PORT_W-1:0]   r_res_granted, n_res_granted;
    t_status             r_res_status, n_res_status;
    logic [PORT_W-1:0]   r_out_granted, n_out_granted;
    t_status             r_out_status, n_out_status;

    logic                 w_ram_we, w_ram_re;
    logic [ADDR_W-1:0]    w_ram_waddr;
    logic [WORD_BITS-1:0] w_ram_wdata, w_rdata;

    logic [NUM_W-1:0]  w_low_ext, w_high_ext, w_end, w_end_m1, w_port_ext, w_grant_num;
    logic              w_empty, w_rel_in_range, w_rel_set;
    logic [ADDR_W-1:0] w_first_word, w_last_word;
    t_scan_ctl         w_scan_ctl;
    t_scan_res         w_scan_res;

    // Search window from the configured range, clipped to the bitmap
    assign w_low_ext    = NUM_W'(r_low);
    assign w_high_ext   = NUM_W'(r_high);
    assign w_end        = (w_high_ext > CAP_NUM) ? CAP_NUM : w_high_ext;
    assign w_empty      = (w_low_ext >= w_end);
    assign w_end_m1     = w_end - NUM_W'(1);
    assign w_first_word = ADDR_W'(w_low_ext >> BIT_W);
    assign w_last_word  = ADDR_W'(w_end_m1 >> BIT_W);

    // Release target
    assign w_port_ext     = NUM_W'(i_req.port);
    assign w_rel_in_range = (w_port_ext < CAP_NUM);
    assign w_rel_set      = w_rdata[r_bit];

    // Shared word scanner
    assign w_scan_ctl.lo_bit = w_low_ext[BIT_W-1:0];
    assign w_scan_ctl.hi_bit = w_end_m1[BIT_W-1:0];
    assign w_scan_ctl.use_lo = (r_word == w_first_word);
    assign w_scan_ctl.use_hi = (r_word == w_last_word);

    pba_word_scan u_scan (
        .i_word (w_rdata),
        .i_ctl  (w_scan_ctl),
        .o_res  (w_scan_res)
    );

    assign w_grant_num = (NUM_W'(r_word) << BIT_W) | NUM_W'(w_scan_res.idx);

    pba_bitmap_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_word),
        .o_rdata (w_rdata)
    );

    // Handshake outputs
    assign i_req.ready        = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_port = r_out_granted;
    assign o_rsp.status       = r_out_status;

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_out_valid   = r_out_valid;
        n_word        = r_word;
        n_bit         = r_bit;
        n_res_granted = r_res_granted;
        n_res_status  = r_res_status;
        n_out_granted = r_out_granted;
        n_out_status  = r_out_status;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;
        w_ram_waddr   = r_word;
        w_ram_wdata   = '0;

        // Drop the response once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_granted = '0;
                    if (i_req.req_type == REQ_RESERVE) begin
                        if (w_empty) begin
                            n_res_status = ST_NO_FREE;
                            n_state      = S_DONE;
                        end else begin
                            n_word  = w_first_word;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_word = ADDR_W'(w_port_ext >> BIT_W);
                        n_bit  = i_req.port[BIT_W-1:0];
                        if (w_rel_in_range) begin
                            n_state = S_REL_RD;
                        end else begin
                            n_res_status = ST_NOT_RESERVED;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                w_ram_re = 1'b1;
                n_state  = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (w_scan_res.found) begin
                    w_ram_we      = 1'b1;
                    w_ram_wdata   = w_scan_res.set_word;
                    n_res_granted = w_grant_num[PORT_W-1:0];
                    n_res_status  = ST_OK;
                    n_state       = S_DONE;
                end else if (r_word == w_last_word) begin
                    n_res_status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_word  = r_word + ADDR_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_REL_RD: begin
                w_ram_re = 1'b1;
                n_state  = S_REL_EV;
            end
            S_REL_EV: begin
                if (w_rel_set) begin
                    w_ram_we     = 1'b1;
                    w_ram_wdata  = w_rdata & ~(WORD_BITS'(1) << r_bit);
                    n_res_status = ST_OK;
                end else begin
                    n_res_status = ST_NOT_RESERVED;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand over once the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_res_granted;
                    n_out_status  = r_res_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_low       <= RANGE_LO_RESET;
            r_high      <= RANGE_HI_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_RANGE_LO) begin
                    r_low <= i_cfg.data[PORT_W-1:0];
                end else if (i_cfg.index == REG_RANGE_HI) begin
                    r_high <= i_cfg.data[PORT_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word        <= n_word;
        r_bit         <= n_bit;
        r_res_granted <= n_res_granted;
        r_res_status  <= n_res_status;
        r_out_granted <= n_out_granted;
        r_out_status  <= n_out_status;
    end

    // A granted number lies inside the configured window
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EV && w_scan_res.found) |->
            (w_grant_num >= w_low_ext && w_grant_num < w_end))
        else $error("granted number outside the reserve window");

    // The scan never passes the last word of the window
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD) |-> (r_word >= w_first_word && r_word <= w_last_word))
        else $error("scan word outside the window");

    // Bitmap writes only during clearing, reserve or release evaluation
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_CLEAR || r_state == S_SCAN_EV || r_state == S_REL_EV))
        else $error("bitmap written outside a write state");

    // A finished result waits while the output register is still occupied
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("result overwrote an untaken response");

endmodule

@@ sim/port_bitmap_allocator_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// port_bitmap_allocator_test: self-checking bench for the bitmap allocator
// Feeds reserve and release requests over a range of low/high settings,
// predicts each response from a local copy of the bitmap and the range
// registers, and checks every response transaction in order.
// ---------------------------------------------------------------------------
module port_bitmap_allocator_test;
    import pba_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [PORT_W-1:0] granted;
        t_status           status;
    } t_grant;

    typedef struct {
        logic              req_type;
        logic [PORT_W-1:0] port;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pba_cfg_if cfg_ch ();
    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();

    port_bitmap_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Local copy of the allocator state
    logic [WORD_BITS-1:0] map_words [WORD_COUNT];
    logic [PORT_W-1:0]    range_low;
    logic [PORT_W-1:0]    range_high;

    t_request pending_requests [$];
    t_grant   due_grants [$];

    int  sent_count  = 0;
    int  acc_count   = 0;
    int  rsp_count   = 0;
    int  fail_count  = 0;
    int  idle_cycles = 0;
    int  snd_idle_pct = 28;
    int  rcv_idle_pct = 84;
    logic hold_req = 1'b0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Work out the response of one request and update the local bitmap
    function automatic t_grant compute_grant(input logic rtype, input logic [PORT_W-1:0] port);
        t_grant res;
        int     stop;
        int     n;
        int     w;
        int     b;
        res.granted = '0;
        if (rtype == REQ_RESERVE) begin
            res.status = ST_NO_FREE;
            stop = (int'(range_high) > BIT_CAPACITY) ? BIT_CAPACITY : int'(range_high);
            n = int'(range_low);
            while (n < stop) begin
                w = n / WORD_BITS;
                b = n % WORD_BITS;
                if (b == 0 && (&map_words[w])) begin
                    // whole word taken, skip it
                    n += WORD_BITS;
                end else if (!map_words[w][b]) begin
                    map_words[w][b] = 1'b1;
                    res.granted = PORT_W'(n);
                    res.status = ST_OK;
                    break;
                end else begin
                    n++;
                end
            end
        end else begin
            n = int'(port);
            w = n / WORD_BITS;
            b = n % WORD_BITS;
            if (n < BIT_CAPACITY && map_words[w][b]) begin
                map_words[w][b] = 1'b0;
                res.status = ST_OK;
            end else begin
                res.status = ST_NOT_RESERVED;
            end
        end
        return res;
    endfunction

    // Request driver: advance on acceptance, idle at random or on hold
    always @(posedge i_clk) begin : req_driver
        t_request item;
        if (!i_rst_n) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= REQ_RESERVE;
            req_ch.port     <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 && !hold_req &&
                $urandom_range(99) >= snd_idle_pct) begin
                item = pending_requests.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= item.req_type;
                req_ch.port     <= item.port;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response sink: stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: track register writes, predict on request, check on response
    always @(posedge i_clk) begin : monitor
        t_grant want;
        logic   moved;
        if (!i_rst_n) begin
            for (int i = 0; i < WORD_COUNT; i++) begin
                map_words[i] = '0;
            end
            range_low  = RANGE_LO_RESET;
            range_high = RANGE_HI_RESET;
        end else begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                if (cfg_ch.index == REG_RANGE_LO) begin
                    range_low = cfg_ch.data;
                end else if (cfg_ch.index == REG_RANGE_HI) begin
                    range_high = cfg_ch.data;
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                moved = 1'b1;
                due_grants.push_back(compute_grant(req_ch.req_type, req_ch.port));
                acc_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                rsp_count++;
                if (due_grants.size() == 0) begin
                    $error("response transaction with nothing outstanding: port %0d status %0d",
                           rsp_ch.granted_port, rsp_ch.status);
                    fail_count++;
                end else begin
                    want = due_grants.pop_front();
                    if (rsp_ch.granted_port !== want.granted) begin
                        $error("granted_port: expected %0d, got %0d",
                               want.granted, rsp_ch.granted_port);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                end
            end
            // Watchdog on cycles without any transaction
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic rtype, input logic [PORT_W-1:0] port);
        t_request item;
        item.req_type = rtype;
        item.port     = port;
        pending_requests.push_back(item);
        sent_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_range(input int lo, input int hi);
        write_reg(REG_RANGE_LO, CFG_DATA_W'(lo));
        write_reg(REG_RANGE_HI, CFG_DATA_W'(hi));
    endtask

    // Hold until every queued request has had its response
    task automatic wait_settled();
        while (rsp_count < sent_count) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int lo_n;
        int hi_n;
        int win_hi;
        int kind;
        int reserve_pct;
        // Known values on every input from time zero
        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_RESERVE;
        req_ch.port     = '0;
        rsp_ch.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset range: lowest numbers first, re-use of a freed number
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RESERVE, 16'h1234);
        queue_request(REQ_RESERVE, 16'hFFFF);
        queue_request(REQ_RELEASE, 16'd12001);
        queue_request(REQ_RELEASE, 16'd12001);
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RELEASE, 16'h0000);
        queue_request(REQ_RELEASE, 16'hFFFF);
        queue_request(REQ_RELEASE, 16'd12000);
        queue_request(REQ_RELEASE, 16'd12001);
        queue_request(REQ_RELEASE, 16'd12002);
        wait_settled();

        // Number zero granted, range exhausted; unknown indexes ignored
        write_reg(CFG_IDX_W'(2), 16'hFFFF);
        write_reg(CFG_IDX_W'(255), 16'h5A5A);
        set_range(0, 2);
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RELEASE, 16'h0000);
        queue_request(REQ_RELEASE, 16'h0001);
        wait_settled();

        // Empty and inverted ranges
        set_range(65535, 0);
        queue_request(REQ_RESERVE, 16'h0000);
        wait_settled();
        set_range(300, 300);
        queue_request(REQ_RESERVE, 16'h0000);
        wait_settled();

        // Top word of the bitmap; the top number itself is never reachable
        set_range(65504, 65535);
        queue_request(REQ_RESERVE, 16'h0000);
        queue_request(REQ_RELEASE, 16'd65504);
        wait_settled();

        // Random phases, each with its own range and reserve/release mix
        for (int ph = 0; ph < 42; ph++) begin
            if (ph == 14) begin
                snd_idle_pct <= 84;
                rcv_idle_pct <= 28;
            end else if (ph == 28) begin
                snd_idle_pct <= 0;
                rcv_idle_pct <= 0;
            end
            kind = $urandom_range(99);
            if (kind < 10) begin
                // wide range over numbers left reserved by earlier phases
                lo_n = $urandom_range(0, 1000);
                hi_n = 65535;
            end else if (kind < 20) begin
                // empty or inverted range
                hi_n = $urandom_range(0, 65535);
                lo_n = hi_n + $urandom_range(0, 40);
                if (lo_n > 65535) lo_n = 65535;
            end else begin
                lo_n = (kind < 60) ? $urandom_range(0, 511) : $urandom_range(0, 65535);
                hi_n = lo_n + $urandom_range(1, 96);
                if (hi_n > 65535) hi_n = 65535;
            end
            set_range(lo_n, hi_n);
            if (ph % 7 == 3) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            end

            win_hi = (hi_n > lo_n) ? hi_n : lo_n + 32;
            if (win_hi > 65536) win_hi = 65536;
            reserve_pct = $urandom_range(30, 80);
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(99) < reserve_pct) begin
                    queue_request(REQ_RESERVE, PORT_W'($urandom));
                end else if ($urandom_range(99) < 80) begin
                    queue_request(REQ_RELEASE, PORT_W'($urandom_range(lo_n, win_hi - 1)));
                end else begin
                    queue_request(REQ_RELEASE, PORT_W'($urandom));
                end
            end

            // Now and then hold the sender until everything in flight is answered
            if (ph % 10 == 5) begin
                while (pending_requests.size() > 20) @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                while (req_ch.valid || rsp_count != acc_count) @(posedge i_clk);
                hold_req <= 1'b0;
            end
            wait_settled();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pba_pkg.sv
rtl/pba_if.sv
rtl/pba_bitmap_ram.sv
rtl/pba_word_scan.sv
rtl/port_bitmap_allocator.sv
sim/port_bitmap_allocator_test.sv
